// ===== hw/rtl/tzve_pkg.sv =====
// Shared types and constants for the tagged zigzag varint encoder.
// Holds the beat structs, format codes, sequencer states and shift-unit control.
// No dependencies.
`timescale 1ns / 1ps

package tzve_pkg;

    localparam int unsigned ValW   = 64;
    localparam int unsigned ByteW  = 8;
    localparam int unsigned DigitW = 7;
    localparam int unsigned CntW   = 4;

    // Format codes carried in the cmd field.
    localparam logic [2:0] CMD_I32  = 3'd0;
    localparam logic [2:0] CMD_I64  = 3'd1;
    localparam logic [2:0] CMD_LEN  = 3'd2;
    localparam logic [2:0] CMD_F32  = 3'd3;
    localparam logic [2:0] CMD_F64  = 3'd4;
    localparam logic [2:0] CMD_BYTE = 3'd5;

    localparam logic [CntW-1:0] F32_BYTES  = 4'd4;
    localparam logic [CntW-1:0] F64_BYTES  = 4'd8;
    localparam logic [CntW-1:0] BYTE_BYTES = 4'd1;

    typedef struct packed {
        logic [2:0]       cmd;
        logic [ValW-1:0]  value;
        logic             with_tag;
        logic [ByteW-1:0] tag_byte;
    } t_in_beat;

    typedef struct packed {
        logic [ByteW-1:0] out_byte;
        logic             last;
        logic [CntW-1:0]  byte_total;
    } t_out_beat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TAG,
        ST_BODY
    } t_state;

    // Commands from the sequencer to the shift unit.
    typedef struct packed {
        logic load;
        logic step;
    } t_sh_ctl;

    // Current byte offered by the shift unit.
    typedef struct packed {
        logic [ByteW-1:0] cur_byte;
        logic             fin;
    } t_sh_sts;

endpackage

// ===== hw/rtl/tagged_zigzag_varint_encoder.sv =====
// Channel   Ports                       Beat type   Contents
// input     i_valid / o_ready / i_data  t_in_beat   cmd, value, with_tag, tag_byte
// output    o_valid / i_ready / o_data  t_out_beat  out_byte, last, byte_total
//
// An item is loaded first and then emits 1 to 11 bytes, the optional tag included;
// while the output is not stalled, the shift unit produces one byte per cycle.
// Items with an unused format are taken and produce nothing.
// Reset is synchronous and active low; it idles the sequencer and empties the output.
// A stalled output holds the sequencer; a new item is taken while the final byte waits.
// Depends on tzve_pkg, tzve_shifter and tzve_seq.
`timescale 1ns / 1ps

module tagged_zigzag_varint_encoder (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  tzve_pkg::t_in_beat    i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output tzve_pkg::t_out_beat   o_data
);
    import tzve_pkg::*;

    t_sh_ctl sh_ctl;
    t_sh_sts sh_sts;

    tzve_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_data   (i_data),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_data   (o_data),
        .o_sh_ctl (sh_ctl),
        .i_sh_sts (sh_sts)
    );

    tzve_shifter u_shifter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sh_ctl),
        .i_cmd   (i_data.cmd),
        .i_value (i_data.value),
        .o_sts   (sh_sts)
    );

endmodule

// ===== hw/rtl/tzve_shifter.sv =====
// Shared shift unit: holds the value being serialized and yields one byte per step.
// Varints shift right by seven bits, big-endian formats shift left by a byte.
// Depends on tzve_pkg.
`timescale 1ns / 1ps

module tzve_shifter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tzve_pkg::t_sh_ctl     i_ctl,
    input  logic [2:0]            i_cmd,
    input  logic [63:0]           i_value,
    output tzve_pkg::t_sh_sts     o_sts
);
    import tzve_pkg::*;

    logic [ValW-1:0] r_val, n_val;
    logic            r_varint, n_varint;
    logic [CntW-1:0] r_left, n_left;

    logic [31:0] zz32;
    logic [63:0] zz64;
    logic        more;

    // Zigzag maps sign into bit 0: (n << 1) ^ (n >> (w-1)).
    assign zz32 = {i_value[30:0], 1'b0} ^ {32{i_value[31]}};
    assign zz64 = {i_value[62:0], 1'b0} ^ {64{i_value[63]}};

    assign more = |r_val[ValW-1:DigitW];

    always_comb begin
        if (r_varint) begin
            o_sts.cur_byte = more ? {1'b1, r_val[DigitW-1:0]} : r_val[ByteW-1:0];
            o_sts.fin      = !more;
        end else begin
            o_sts.cur_byte = r_val[ValW-1 -: ByteW];
            o_sts.fin      = (r_left == BYTE_BYTES);
        end
    end

    always_comb begin
        n_val    = r_val;
        n_varint = r_varint;
        n_left   = r_left;
        if (i_ctl.load) begin
            case (i_cmd)
                CMD_I32: begin
                    n_val    = {32'd0, zz32};
                    n_varint = 1'b1;
                end
                CMD_I64: begin
                    n_val    = zz64;
                    n_varint = 1'b1;
                end
                CMD_LEN: begin
                    n_val    = {32'd0, i_value[31:0]};
                    n_varint = 1'b1;
                end
                CMD_F32: begin
                    n_val    = {i_value[31:0], 32'd0};
                    n_varint = 1'b0;
                    n_left   = F32_BYTES;
                end
                CMD_F64: begin
                    n_val    = i_value;
                    n_varint = 1'b0;
                    n_left   = F64_BYTES;
                end
                default: begin
                    n_val    = {i_value[7:0], 56'd0};
                    n_varint = 1'b0;
                    n_left   = BYTE_BYTES;
                end
            endcase
        end else if (i_ctl.step) begin
            if (r_varint) begin
                n_val = r_val >> DigitW;
            end else begin
                n_val  = r_val << ByteW;
                n_left = r_left - 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        if (!i_rst_n) begin
            r_varint <= 1'b0;
            r_left   <= '0;
        end else begin
            r_varint <= n_varint;
            r_left   <= n_left;
        end
    end

endmodule

// ===== hw/rtl/tzve_seq.sv =====
// Sequencer: accepts an item, emits the optional tag, then drives the shift unit
// one byte per cycle, unless the output stalls, into the output register. Depends on tzve_pkg.
`timescale 1ns / 1ps

module tzve_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  tzve_pkg::t_in_beat    i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output tzve_pkg::t_out_beat   o_data,
    output tzve_pkg::t_sh_ctl     o_sh_ctl,
    input  tzve_pkg::t_sh_sts     i_sh_sts
);
    import tzve_pkg::*;

    t_state          r_state, n_state;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic [ByteW-1:0] r_tag, n_tag;
    logic            r_ovalid, n_ovalid;
    t_out_beat       r_out, n_out;

    logic can_emit;
    logic known_cmd;

    assign can_emit  = !r_ovalid || i_ready;
    assign known_cmd = i_data.cmd inside {[CMD_I32:CMD_BYTE]};

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_tag     = r_tag;
        n_out     = r_out;
        n_ovalid  = r_ovalid && !i_ready;
        o_ready   = 1'b0;
        o_sh_ctl  = '0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                // Unknown formats are taken and dropped without output.
                if (i_valid && known_cmd) begin
                    o_sh_ctl.load = 1'b1;
                    n_tag         = i_data.tag_byte;
                    n_cnt         = '0;
                    n_state       = i_data.with_tag ? ST_TAG : ST_BODY;
                end
            end
            ST_TAG: begin
                if (can_emit) begin
                    n_out    = '{out_byte: r_tag, last: 1'b0, byte_total: '0};
                    n_ovalid = 1'b1;
                    n_cnt    = 4'd1;
                    n_state  = ST_BODY;
                end
            end
            ST_BODY: begin
                if (can_emit) begin
                    o_sh_ctl.step    = 1'b1;
                    n_cnt            = r_cnt + 4'd1;
                    n_out.out_byte   = i_sh_sts.cur_byte;
                    n_out.last       = i_sh_sts.fin;
                    n_out.byte_total = i_sh_sts.fin ? (r_cnt + 4'd1) : '0;
                    n_ovalid         = 1'b1;
                    if (i_sh_sts.fin) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_tag <= n_tag;
        r_out <= n_out;
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

endmodule

// ===== tb/tagged_zigzag_varint_encoder_test.sv =====
// Self-checking bench for the tagged zigzag varint encoder: queued directed and random items,
// predicted byte stream per item, checked beat by beat under random idling and a long stall.
// Depends on tzve_pkg and tagged_zigzag_varint_encoder.
`timescale 1ns / 1ps

module tagged_zigzag_varint_encoder_test;

    import tzve_pkg::*;

    // Format codes the block ignores.
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

    localparam int RandomItems = 500;
    localparam int DrainCycles = 24;
    localparam int HoldCycles  = 150;
    localparam int HoldAtBeat  = 200;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      i_ready = 1'b0;
    t_in_beat  i_data  = '0;
    logic      o_ready;
    logic      o_valid;
    t_out_beat o_data;

    t_in_beat  pending_items [$];
    t_out_beat expected_bytes [$];

    int errors      = 0;
    int items_taken = 0;
    int beats_seen  = 0;
    int send_wait   = 0;
    int recv_wait   = 0;
    int hold_cnt    = 0;
    bit hold_done   = 1'b0;

    tagged_zigzag_varint_encoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Stretches of 32 with no idling alternate with stretches of random waits.
    function automatic int draw_wait(input int count);
        return count[5] ? 0 : int'($urandom_range(0, 8));
    endfunction

    // Appends the byte stream that one item produces to the expected store.
    function automatic void encode_item(input t_in_beat item);
        logic [7:0]  stream [$];
        logic [63:0] digits;
        logic [31:0] word;
        bit          is_varint;
        t_out_beat   beat;
        int          n;
        if (item.cmd > CMD_BYTE) return;
        is_varint = 1'b0;
        digits    = '0;
        if (item.with_tag) stream.push_back(item.tag_byte);
        case (item.cmd)
            CMD_I32: begin
                word      = item.value[31:0];
                word      = (word << 1) ^ {32{word[31]}};
                digits    = {32'b0, word};
                is_varint = 1'b1;
            end
            CMD_I64: begin
                digits    = (item.value << 1) ^ {64{item.value[63]}};
                is_varint = 1'b1;
            end
            CMD_LEN: begin
                digits    = {32'b0, item.value[31:0]};
                is_varint = 1'b1;
            end
            CMD_F32: begin
                for (int i = 3; i >= 0; i--) stream.push_back(item.value[i*8 +: 8]);
            end
            CMD_F64: begin
                for (int i = 7; i >= 0; i--) stream.push_back(item.value[i*8 +: 8]);
            end
            default: begin
                stream.push_back(item.value[7:0]);
            end
        endcase
        if (is_varint) begin
            while (digits[63:7] != '0) begin
                stream.push_back({1'b1, digits[6:0]});
                digits = digits >> 7;
            end
            stream.push_back(digits[7:0]);
        end
        n = stream.size();
        for (int k = 0; k < n; k++) begin
            beat.out_byte   = stream[k];
            beat.last       = (k == n - 1);
            beat.byte_total = (k == n - 1) ? n[3:0] : '0;
            expected_bytes.push_back(beat);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("beat %0d: %s expected 0x%0h got 0x%0h", beats_seen, what, want, got);
        errors++;
    endtask

    task automatic queue_item(input logic [2:0] cmd, input logic [63:0] value,
                              input logic tag_on, input logic [7:0] tag);
        t_in_beat item;
        item.cmd      = cmd;
        item.value    = value;
        item.with_tag = tag_on;
        item.tag_byte = tag;
        pending_items.push_back(item);
    endtask

    // Sender: the payload is sampled at the edge that accepts it, so the prediction
    // is queued before any of its bytes can come out.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                encode_item(i_data);
                items_taken++;
            end
            if (!i_valid || o_ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    i_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    i_data    <= pending_items.pop_front();
                    i_valid   <= 1'b1;
                    send_wait = draw_wait(items_taken);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each accepted beat and decides ready for the next edge.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch("unexpected beat, out_byte", 8'h00, o_data.out_byte);
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_data.out_byte !== want.out_byte)
                        report_mismatch("out_byte", want.out_byte, o_data.out_byte);
                    if (o_data.last !== want.last)
                        report_mismatch("last", {7'b0, want.last}, {7'b0, o_data.last});
                    if (o_data.byte_total !== want.byte_total)
                        report_mismatch("byte_total", {4'b0, want.byte_total},
                                        {4'b0, o_data.byte_total});
                end
                beats_seen++;
                recv_wait = draw_wait(beats_seen);
                // One long stall lets the block fill up and push back on the sender.
                if (!hold_done && beats_seen >= HoldAtBeat) begin
                    hold_done = 1'b1;
                    hold_cnt  = HoldCycles;
                end
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [63:0] value;
        logic [2:0]  cmd;
        int          queued;
        // Directed items: field extremes, every format, varint length boundaries.
        queue_item(CMD_I32, 64'h0, 1'b0, 8'h00);
        queue_item(CMD_I32, 64'hDEADBEEF_00000001, 1'b0, 8'h00);
        queue_item(CMD_I32, 64'h0000_0000_FFFF_FFFF, 1'b1, 8'hFF);
        queue_item(CMD_I32, 64'h0000_0000_7FFF_FFFF, 1'b0, 8'h00);
        queue_item(CMD_I32, 64'hFFFF_FFFF_8000_0000, 1'b1, 8'h00);
        queue_item(CMD_I32, 64'd63, 1'b0, 8'h00);
        queue_item(CMD_I32, 64'd64, 1'b0, 8'h00);
        queue_item(CMD_I64, 64'h0, 1'b0, 8'h00);
        queue_item(CMD_I64, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'hFF);
        queue_item(CMD_I64, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 8'hA5);
        queue_item(CMD_I64, 64'h8000_0000_0000_0000, 1'b0, 8'h00);
        queue_item(CMD_LEN, 64'h0, 1'b0, 8'h00);
        queue_item(CMD_LEN, 64'h7F, 1'b1, 8'h5A);
        queue_item(CMD_LEN, 64'h80, 1'b0, 8'h00);
        queue_item(CMD_LEN, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'h00);
        queue_item(CMD_F32, 64'hFFFF_FFFF_3F80_0000, 1'b1, 8'h01);
        queue_item(CMD_F32, 64'h0, 1'b0, 8'h00);
        queue_item(CMD_F64, 64'h0123_4567_89AB_CDEF, 1'b1, 8'h80);
        queue_item(CMD_F64, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'h00);
        queue_item(CMD_BYTE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'h00);
        queue_item(CMD_BYTE, 64'hFFFF_FFFF_FFFF_FF00, 1'b1, 8'h7F);
        queue_item(CMD_SPARE_A, 64'h1234, 1'b1, 8'hEE);
        queue_item(CMD_SPARE_B, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'hFF);
        queue_item(CMD_BYTE, 64'h42, 1'b0, 8'h00);

        // Random items: magnitudes spread so every varint length shows up.
        queued = 0;
        while (queued < RandomItems) begin
            value = {$urandom, $urandom};
            case ($urandom_range(0, 3))
                0: value = value >> $urandom_range(0, 63);
                1: value = ~(value >> $urandom_range(0, 63));
                2: value = value & 64'hFF;
                default: ;
            endcase
            if ($urandom_range(0, 19) == 0) begin
                cmd = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
            end else begin
                cmd = 3'($urandom_range(0, 5));
                queued++;
            end
            queue_item(cmd, value, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_valid || expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (errors == 0) begin
            $display("tagged_zigzag_varint_encoder regression: pass");
        end else begin
            $display("tagged_zigzag_varint_encoder regression: fail");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("timeout with %0d beats still expected", expected_bytes.size());
        $display("tagged_zigzag_varint_encoder regression: fail");
        $finish;
    end

endmodule
